// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the note to frequency core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i, masked while rst_ni is low.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/ntf_pkg.sv =====
// Shared constants, types and helper functions of the note to frequency core.
package ntf_pkg;

  localparam int unsigned NoteW     = 7;
  localparam int unsigned BaseFreqW = 18;
  localparam int unsigned FreqW     = 31;
  localparam int unsigned RomW      = 15;
  localparam int unsigned OctW      = 4;
  localparam int unsigned SemiW     = 4;
  localparam int unsigned SemisPerOct = 12;
  // Octave numbers of 7-bit notes run from 0 to 10.
  localparam int unsigned MaxShift  = 10;
  localparam int unsigned ShiftW    = BaseFreqW + MaxShift;
  localparam int unsigned ProdW     = ShiftW + RomW;
  // The largest product divided by the smallest table word stays below 2**29,
  // so the division only has to produce 29 quotient bits.
  localparam int unsigned QuotW     = 29;
  localparam int unsigned RemW      = RomW;

  localparam int unsigned CfgIdxW   = 1;
  localparam logic [CfgIdxW-1:0] CfgBaseFreq = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBaseNote = 1'b1;

  localparam logic [BaseFreqW-1:0] BaseFreqReset = 18'd44100;
  localparam logic [NoteW-1:0]     BaseNoteReset = 7'd36;

  // Word handed from one division cell to the next.
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] acc;
    logic [RomW-1:0]  divisor;
  } div_word_t;

  // note / 12 as a multiply by 43 and a shift by 9, exact for 7-bit notes.
  function automatic logic [OctW-1:0] octave_of(input logic [NoteW-1:0] note);
    logic [12:0] p;
    p = 13'(note) * 13'd43;
    return p[12:9];
  endfunction

  function automatic logic [SemiW-1:0] semitone_of(input logic [NoteW-1:0] note);
    logic [NoteW-1:0] base;
    base = NoteW'(octave_of(note)) * NoteW'(SemisPerOct);
    return SemiW'(note - base);
  endfunction

  function automatic logic [RomW-1:0] semitone_rom(input logic [SemiW-1:0] semi);
    logic [RomW-1:0] w;
    case (semi)
      4'd0:    w = 15'd10000;
      4'd1:    w = 15'd10594;
      4'd2:    w = 15'd11224;
      4'd3:    w = 15'd11891;
      4'd4:    w = 15'd12598;
      4'd5:    w = 15'd13346;
      4'd6:    w = 15'd14140;
      4'd7:    w = 15'd14980;
      4'd8:    w = 15'd15871;
      4'd9:    w = 15'd16814;
      4'd10:   w = 15'd17813;
      4'd11:   w = 15'd18872;
      default: w = 15'd10000;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/ntf_front.sv =====
// Front stages: octave shift and table lookup, then the wide product.
`include "assert_macros.svh"

module ntf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ntf_pkg::BaseFreqW-1:0] base_freq_i,
  input  logic [ntf_pkg::NoteW-1:0]     base_note_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ntf_pkg::NoteW-1:0]     note_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ntf_pkg::div_word_t            out_word_o
);

  logic [ntf_pkg::OctW-1:0]   oct_n, oct_b;
  logic [ntf_pkg::OctW-1:0]   amount;
  logic [ntf_pkg::ShiftW-1:0] freq_ext, sh_d;
  logic                       rdy_a, rdy_b;

  logic                       va_q, vb_q;
  logic [ntf_pkg::ShiftW-1:0] sh_q;
  logic [ntf_pkg::RomW-1:0]   mul_q, diva_q, divb_q;
  logic [ntf_pkg::ProdW-1:0]  prod_q;

  assign oct_n    = ntf_pkg::octave_of(note_i);
  assign oct_b    = ntf_pkg::octave_of(base_note_i);
  assign freq_ext = ntf_pkg::ShiftW'(base_freq_i);

  always_comb begin
    if (oct_n >= oct_b) begin
      amount = oct_n - oct_b;
      sh_d   = freq_ext << amount;
    end else begin
      amount = oct_b - oct_n;
      sh_d   = freq_ext >> amount;
    end
  end

  assign rdy_b      = !vb_q || out_ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      sh_q   <= sh_d;
      mul_q  <= ntf_pkg::semitone_rom(ntf_pkg::semitone_of(note_i));
      diva_q <= ntf_pkg::semitone_rom(ntf_pkg::semitone_of(base_note_i));
    end
    if (rdy_b && va_q) begin
      prod_q <= ntf_pkg::ProdW'(sh_q) * ntf_pkg::ProdW'(mul_q);
      divb_q <= diva_q;
    end
  end

  assign out_valid_o        = vb_q;
  assign out_word_o.rem     = ntf_pkg::RemW'(prod_q[ntf_pkg::ProdW-1:ntf_pkg::QuotW]);
  assign out_word_o.acc     = prod_q[ntf_pkg::QuotW-1:0];
  assign out_word_o.divisor = divb_q;

  // The upper product bits must already be below the divisor, or the
  // quotient would not fit the cell chain.
  `ASSERT_RST(a_quot_fits,
              vb_q |-> (ntf_pkg::RemW'(prod_q[ntf_pkg::ProdW-1:ntf_pkg::QuotW]) < divb_q),
              "product too large for the quotient width")

endmodule

// ===== hw/rtl/ntf_div_cell.sv =====
// One restoring division cell: one quotient bit per item, registered.
`include "assert_macros.svh"

module ntf_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ntf_pkg::div_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ntf_pkg::div_word_t out_word_o
);

  logic [ntf_pkg::RemW:0]   trial;
  logic                     ge;
  logic                     rdy;
  ntf_pkg::div_word_t       word_d, word_q;
  logic                     v_q;

  assign trial = {in_word_i.rem, in_word_i.acc[ntf_pkg::QuotW-1]};
  assign ge    = trial >= {1'b0, in_word_i.divisor};

  always_comb begin
    word_d.divisor = in_word_i.divisor;
    word_d.acc     = {in_word_i.acc[ntf_pkg::QuotW-2:0], ge};
    if (ge) begin
      word_d.rem = ntf_pkg::RemW'(trial - {1'b0, in_word_i.divisor});
    end else begin
      word_d.rem = trial[ntf_pkg::RemW-1:0];
    end
  end

  assign rdy        = !v_q || out_ready_i;
  assign in_ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_word_o  = word_q;

  `ASSERT_RST(a_rem_below_div, v_q |-> (word_q.rem < word_q.divisor),
              "partial remainder not below divisor")
  `ASSERT_RST(a_hold_on_stall, (v_q && !out_ready_i) |=> (v_q && $stable(word_q)),
              "stalled cell lost its item")

endmodule

// ===== hw/rtl/note_to_frequency_core.sv =====
// Top level of the note to frequency core: config registers, front stages, divider cells.
//
// Usage: a note number enters on the s_axis channel (tdata[6:0]); one frequency
// item leaves on the m_axis channel (tdata[30:0]) for every note, in order.
// The frequency is the base frequency moved by whole octaves, scaled by the
// semitone table word of the note and divided by the word of the base note.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0: base
// frequency, 18 bits; 1: base note, 7 bits); write only while no item is in flight.
// Pipeline: an item passes 31 register stages, the first loaded at the accepting
// edge: two front stages (shift and lookup, then the 28x15 product) and 29 division
// cells, each cell resolving one quotient bit.
// Throughput: one item per cycle; every stage moves on each cycle its successor
// can take an item.
// Reset: all stages empty, base frequency 44100, base note 36.
// Stall: with m_axis_tready low the last cell holds its item, earlier stages
// keep filling their empty slots, and s_axis_tready falls once the chain is full.

module note_to_frequency_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ntf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ntf_pkg::BaseFreqW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [6:0] note_number
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata   // [30:0] frequency
);

  logic [ntf_pkg::BaseFreqW-1:0] base_freq_q;
  logic [ntf_pkg::NoteW-1:0]     base_note_q;

  ntf_pkg::div_word_t word [0:ntf_pkg::QuotW];
  logic               vld  [0:ntf_pkg::QuotW];
  logic               rdy  [0:ntf_pkg::QuotW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_freq_q <= ntf_pkg::BaseFreqReset;
      base_note_q <= ntf_pkg::BaseNoteReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ntf_pkg::CfgBaseFreq: base_freq_q <= cfg_wdata_i;
        ntf_pkg::CfgBaseNote: base_note_q <= cfg_wdata_i[ntf_pkg::NoteW-1:0];
        default: ;
      endcase
    end
  end

  ntf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_freq_i (base_freq_q),
    .base_note_i (base_note_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .note_i      (s_axis_tdata[ntf_pkg::NoteW-1:0]),
    .out_valid_o (vld[0]),
    .out_ready_i (rdy[0]),
    .out_word_o  (word[0])
  );

  for (genvar i = 0; i < ntf_pkg::QuotW; i++) begin : g_cell
    ntf_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[i]),
      .in_ready_o  (rdy[i]),
      .in_word_i   (word[i]),
      .out_valid_o (vld[i+1]),
      .out_ready_i (rdy[i+1]),
      .out_word_o  (word[i+1])
    );
  end

  assign rdy[ntf_pkg::QuotW] = m_axis_tready;
  assign m_axis_tvalid       = vld[ntf_pkg::QuotW];
  assign m_axis_tdata        = 32'(word[ntf_pkg::QuotW].acc);

endmodule

// ===== tb/sv/note_to_frequency_core_tb.sv =====
// Self-checking testbench for the note to frequency core with random flow control.
`timescale 1ns / 1ps

module note_to_frequency_core_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldAfter = 200;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned PhaseNotes = 145;
  localparam int unsigned NumPhases = 10;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_RARE_STALL,
    RX_SLOW
  } rx_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i = 1'b0;
  logic [ntf_pkg::CfgIdxW-1:0]   cfg_idx_i = ntf_pkg::CfgBaseFreq;
  logic [ntf_pkg::BaseFreqW-1:0] cfg_wdata_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;  // [6:0] note_number
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [31:0]                   m_axis_tdata;       // [30:0] frequency

  note_to_frequency_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  int unsigned semitone_word [12] = '{10000, 10594, 11224, 11891, 12598, 13346,
                                      14140, 14980, 15871, 16814, 17813, 18872};

  logic [ntf_pkg::BaseFreqW-1:0] base_freq_cfg = ntf_pkg::BaseFreqReset;
  logic [ntf_pkg::NoteW-1:0]     base_note_cfg = ntf_pkg::BaseNoteReset;

  logic [ntf_pkg::NoteW-1:0] pending_notes [$];
  logic [ntf_pkg::FreqW-1:0] freq_expect_q [$];
  logic [ntf_pkg::FreqW-1:0] freq_want;

  int notes_queued = 0;
  int notes_accepted;
  int freqs_checked;
  int error_count = 0;
  int cycle_count = 0;
  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_done;
  int mode_left;
  int slow_phase;
  rx_mode_e rx_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ntf_pkg::FreqW-1:0] expected_frequency(
      input logic [ntf_pkg::NoteW-1:0] note);
    int unsigned oct_note;
    int unsigned oct_base;
    logic [63:0] scaled;
    logic [63:0] quot;
    oct_note = note / 12;
    oct_base = base_note_cfg / 12;
    scaled = 64'(base_freq_cfg);
    // Negative octave distance shifts right, dropping the low bits.
    if (oct_note >= oct_base) scaled = scaled << (oct_note - oct_base);
    else scaled = scaled >> (oct_base - oct_note);
    quot = (scaled * 64'(semitone_word[note % 12])) / 64'(semitone_word[base_note_cfg % 12]);
    if (quot > 64'h7FFF_FFFF) quot = 64'h7FFF_FFFF;
    return quot[ntf_pkg::FreqW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [ntf_pkg::CfgIdxW-1:0] idx,
                           input logic [ntf_pkg::BaseFreqW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ntf_pkg::CfgBaseFreq) base_freq_cfg = value;
    else base_note_cfg = value[ntf_pkg::NoteW-1:0];
  endtask

  task automatic queue_note(input logic [ntf_pkg::NoteW-1:0] note);
    pending_notes.push_back(note);
    notes_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (freqs_checked != notes_queued);
  endtask

  // Note sender: bursts of items separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_notes.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= 8'(pending_notes.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Frequency receiver: stall pattern changes at random intervals, plus one long hold-off
  // that lets the chain fill and push back on the note input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      mode_left <= 0;
      slow_phase <= 0;
      rx_mode <= RX_FREE;
    end else begin
      slow_phase <= (slow_phase + 1) % 4;
      if (mode_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && notes_accepted >= HoldAfter) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:       m_axis_tready <= 1'b1;
          RX_COIN:       m_axis_tready <= 1'($urandom_range(0, 1));
          RX_RARE_STALL: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default:       m_axis_tready <= (slow_phase == 0);
        endcase
      end
    end
  end

  // Predicts on every accepted note and checks every accepted frequency in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notes_accepted <= 0;
      freqs_checked <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        freq_expect_q.push_back(expected_frequency(s_axis_tdata[ntf_pkg::NoteW-1:0]));
        notes_accepted <= notes_accepted + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        freqs_checked <= freqs_checked + 1;
        if (freq_expect_q.size() == 0) begin
          report_mismatch($sformatf("frequency %0d with no note pending",
                                    m_axis_tdata[ntf_pkg::FreqW-1:0]));
        end else begin
          freq_want = freq_expect_q.pop_front();
          if (m_axis_tdata[ntf_pkg::FreqW-1:0] !== freq_want)
            report_mismatch($sformatf("frequency %0d, expected %0d",
                                      m_axis_tdata[ntf_pkg::FreqW-1:0], freq_want));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [ntf_pkg::BaseFreqW-1:0] phase_freq [5];
    logic [ntf_pkg::NoteW-1:0]     phase_base [5];
    logic [ntf_pkg::BaseFreqW-1:0] freq_val;
    logic [ntf_pkg::NoteW-1:0]     base_val;
    logic [ntf_pkg::NoteW-1:0]     note;
    int unsigned                   boundary;

    phase_freq = '{18'h3FFFF, 18'd1, 18'd0, 18'h3FFFF, 18'd1};
    phase_base = '{7'd0, 7'd127, 7'd60, 7'd127, 7'd0};

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: range ends, every semitone, octave edges around the base note,
    // and alternating bit patterns.
    @(negedge clk_i);
    foreach (semitone_word[i]) queue_note(ntf_pkg::NoteW'(i));
    queue_note(7'd127);
    queue_note(7'd12);
    queue_note(7'd35);
    queue_note(7'd36);
    queue_note(7'd37);
    queue_note(7'd47);
    queue_note(7'd48);
    queue_note(7'd119);
    queue_note(7'd120);
    queue_note(7'h55);
    queue_note(7'h2A);
    wait_drained();

    // Extreme settings first (largest left shift, shifts down to zero, zero base
    // frequency), then random settings.
    for (int p = 0; p < NumPhases; p++) begin
      if (p < 5) begin
        freq_val = phase_freq[p];
        base_val = phase_base[p];
      end else begin
        freq_val = ($urandom_range(0, 3) == 0)
                   ? ntf_pkg::BaseFreqW'($urandom_range(1, 64))
                   : ntf_pkg::BaseFreqW'($urandom_range(1, 262143));
        base_val = ntf_pkg::NoteW'($urandom_range(0, 127));
      end
      write_reg(ntf_pkg::CfgBaseFreq, freq_val);
      // Bits above the base note field are junk and must be ignored.
      write_reg(ntf_pkg::CfgBaseNote, {11'($urandom_range(0, 2047)), base_val});
      @(negedge clk_i);
      for (int n = 0; n < PhaseNotes; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          boundary = $urandom_range(0, 10) * 12 + (($urandom_range(0, 1) != 0) ? 11 : 0);
          note = (boundary > 127) ? 7'd127 : ntf_pkg::NoteW'(boundary);
        end else begin
          note = ntf_pkg::NoteW'($urandom_range(0, 127));
        end
        queue_note(note);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ntf_pkg.sv
hw/rtl/ntf_front.sv
hw/rtl/ntf_div_cell.sv
hw/rtl/note_to_frequency_core.sv
tb/sv/note_to_frequency_core_tb.sv
